// ===== sv/axis_rotation_orbit_points_core_macros.svh =====
// Assertion macros for the checker module of the orbit point core.
`ifndef AXIS_ROTATION_ORBIT_POINTS_CORE_MACROS_SVH
`define AXIS_ROTATION_ORBIT_POINTS_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define AROP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// Clocked assertion that also holds while reset is high.
`define AROP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== sv/arop_pkg.sv =====
// Package of types, constants and tables for the axis rotation orbit point core.
`default_nettype none
package arop_pkg;

  localparam int MAX_ORBIT_DEF    = 64;
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 25;

  localparam logic [STEP_W-1:0]         FULL_TURN    = 25'd23592960;
  localparam logic [STEP_W-1:0]         STEP_RESET   = 25'd7864320;
  localparam logic signed [COORD_W-1:0] AXIS_Z_RESET = 32'sd65536;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 4'd7;

  // Datapath widths.
  localparam int P_W    = 33;  // point minus center
  localparam int ACC_W  = 40;  // dot, cross, w and r sums
  localparam int MA_W   = 40;  // signed multiplier operand A
  localparam int MB_W   = 36;  // signed multiplier operand B
  localparam int HALF_A = 19;  // A magnitude is handled as two halves
  localparam int MAG_B  = 34;
  localparam int PP_W   = HALF_A + MAG_B;
  localparam int PROD_W = 2 * HALF_A + MAG_B;
  localparam int CS_W   = 34;  // CORDIC x and y
  localparam int Z_W    = 33;  // CORDIC residual angle
  localparam int ATAN_W = 30;
  localparam int SQ_W   = 64;
  localparam int DVD_W  = 62;
  localparam int DSR_W  = 33;
  localparam int CNT_W  = 6;   // shared iteration counter of root and divider
  localparam int DEG_W  = 10;

  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'(DVD_W - 1);

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CS_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [DEG_W-1:0]       DEG_FULL    = 10'd360;
  localparam logic [DEG_W-1:0]       DEG_HALF    = 10'd180;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_NORM, ST_MUL, ST_SQRT, ST_DIV_LOAD, ST_DIV,
    ST_POINT, ST_ANGLE, ST_CORDIC, ST_QUAD, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    A_P0, A_P1, A_P2, A_CR0, A_CR1, A_CR2, A_DOT, A_W, A_UA0, A_UA1, A_UA2
  } a_sel_t;

  typedef enum logic [3:0] {
    B_K0, B_K1, B_K2, B_C, B_S, B_OMC, B_UA0, B_UA1, B_UA2
  } b_sel_t;

  typedef enum logic [3:0] {
    D_SQ, D_DOT, D_CR0, D_CR1, D_CR2, D_W, D_R0, D_R1, D_R2
  } dest_t;

  typedef enum logic [2:0] {
    DJ_K0, DJ_K1, DJ_K2, DJ_COUNT, DJ_STEP
  } div_job_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    dest_t  d;
    logic   sub;  // subtract the rounded product from the destination
    logic   raw;  // keep the full product, no Q30 rounding
  } mop_t;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_SQ_LAST     = 5'd2;
  localparam logic [OP_W-1:0] OP_SETUP_LAST  = 5'd11;
  localparam logic [OP_W-1:0] OP_POINT_FIRST = 5'd12;
  localparam logic [OP_W-1:0] OP_LAST        = 5'd21;

  localparam logic [1:0] MST_LAST = 2'd3;

  // Product program: squares for the norm, then dot and cross products,
  // then the per-point Rodrigues terms.
  function automatic mop_t mop_table(input logic [OP_W-1:0] op);
    mop_t m;
    m = '{a: A_P0, b: B_K0, d: D_DOT, sub: 1'b0, raw: 1'b0};
    case (op)
      5'd0:  m = '{a: A_UA0, b: B_UA0, d: D_SQ,  sub: 1'b0, raw: 1'b1};
      5'd1:  m = '{a: A_UA1, b: B_UA1, d: D_SQ,  sub: 1'b0, raw: 1'b1};
      5'd2:  m = '{a: A_UA2, b: B_UA2, d: D_SQ,  sub: 1'b0, raw: 1'b1};
      5'd3:  m = '{a: A_P0,  b: B_K0,  d: D_DOT, sub: 1'b0, raw: 1'b0};
      5'd4:  m = '{a: A_P1,  b: B_K1,  d: D_DOT, sub: 1'b0, raw: 1'b0};
      5'd5:  m = '{a: A_P2,  b: B_K2,  d: D_DOT, sub: 1'b0, raw: 1'b0};
      5'd6:  m = '{a: A_P2,  b: B_K1,  d: D_CR0, sub: 1'b0, raw: 1'b0};
      5'd7:  m = '{a: A_P1,  b: B_K2,  d: D_CR0, sub: 1'b1, raw: 1'b0};
      5'd8:  m = '{a: A_P0,  b: B_K2,  d: D_CR1, sub: 1'b0, raw: 1'b0};
      5'd9:  m = '{a: A_P2,  b: B_K0,  d: D_CR1, sub: 1'b1, raw: 1'b0};
      5'd10: m = '{a: A_P1,  b: B_K0,  d: D_CR2, sub: 1'b0, raw: 1'b0};
      5'd11: m = '{a: A_P0,  b: B_K1,  d: D_CR2, sub: 1'b1, raw: 1'b0};
      5'd12: m = '{a: A_DOT, b: B_OMC, d: D_W,   sub: 1'b0, raw: 1'b0};
      5'd13: m = '{a: A_P0,  b: B_C,   d: D_R0,  sub: 1'b0, raw: 1'b0};
      5'd14: m = '{a: A_CR0, b: B_S,   d: D_R0,  sub: 1'b0, raw: 1'b0};
      5'd15: m = '{a: A_W,   b: B_K0,  d: D_R0,  sub: 1'b0, raw: 1'b0};
      5'd16: m = '{a: A_P1,  b: B_C,   d: D_R1,  sub: 1'b0, raw: 1'b0};
      5'd17: m = '{a: A_CR1, b: B_S,   d: D_R1,  sub: 1'b0, raw: 1'b0};
      5'd18: m = '{a: A_W,   b: B_K1,  d: D_R1,  sub: 1'b0, raw: 1'b0};
      5'd19: m = '{a: A_P2,  b: B_C,   d: D_R2,  sub: 1'b0, raw: 1'b0};
      5'd20: m = '{a: A_CR2, b: B_S,   d: D_R2,  sub: 1'b0, raw: 1'b0};
      5'd21: m = '{a: A_W,   b: B_K2,  d: D_R2,  sub: 1'b0, raw: 1'b0};
      default: m = '{a: A_P0, b: B_K0, d: D_DOT, sub: 1'b0, raw: 1'b0};
    endcase
    return m;
  endfunction

  // Arctangent of 2^-i in binary angle units (2^32 per turn).
  function automatic logic [ATAN_W-1:0] atan_bam(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    v = '0;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/axis_rotation_orbit_points_core.sv =====
// Top level of the axis rotation orbit point core: sequencer and shared units.
//
// One beat on the input channel (point_x/y/z) produces the orbit of that point
// under repeated rotation by step_angle about the configured axis and center:
// floor(360 deg / step) beats on the output channel, capped at MAX_ORBIT, the
// last one flagged by last_of_orbit. A zero axis gives a single beat with zero
// coordinates and bad_axis set; a step above a full turn gives no beats.
// Setup per input runs up to 30 normalize shifts, three squares, a 32-step
// square root and five 62-step restoring divisions. Each orbit point then runs
// up to CORDIC_STEPS rotation steps plus ten products through the shared
// multiplier.
// The block works on one input at a time; in_ready is high only when idle.
// Results go through a single output register, so the next point is held back
// while out_ready is low and the sequencer resumes when the beat is taken.
// Reset returns the configuration to its defaults, empties the output register
// and idles the sequencer. Configuration is written through cfg_write,
// cfg_index and cfg_data; the user must write it only while no input is in
// flight, as the block does not enforce this. Unknown indexes are ignored.
`default_nettype none
module axis_rotation_orbit_points_core #(
  parameter int MAX_ORBIT    = arop_pkg::MAX_ORBIT_DEF,
  parameter int COORD_WIDTH  = arop_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = arop_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [arop_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [arop_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [arop_pkg::COORD_W-1:0]   point_x,
  input  logic signed [arop_pkg::COORD_W-1:0]   point_y,
  input  logic signed [arop_pkg::COORD_W-1:0]   point_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [arop_pkg::COORD_W-1:0]   out_x,
  output logic signed [arop_pkg::COORD_W-1:0]   out_y,
  output logic signed [arop_pkg::COORD_W-1:0]   out_z,
  output logic                                  last_of_orbit,
  output logic                                  bad_axis
);
  import arop_pkg::*;

  localparam int N_W  = $clog2(MAX_ORBIT + 1);
  localparam int IT_W = $clog2(CORDIC_STEPS);
  localparam int V_W  = 50;
  localparam logic signed [V_W-1:0] SAT_HI = (50'sd1 <<< (COORD_WIDTH - 1)) - 50'sd1;
  localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - 50'sd1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  // Configuration registers.
  logic signed [COORD_W-1:0] axis_x, axis_y, axis_z;
  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic [STEP_W-1:0]         step_angle;
  logic                      invert_mode;

  state_t state, state_next;

  logic signed [P_W-1:0]     p0, p1, p2;
  logic [COORD_W-1:0]        ua0, ua1, ua2;
  logic signed [COORD_W-1:0] k0, k1, k2;
  logic signed [ACC_W-1:0]   dot, cr0, cr1, cr2, w, r0, r1, r2;
  logic [SQ_W-1:0]           sq, sqv, sqr, sqbit;
  logic [CNT_W-1:0]          cnt;
  logic [DVD_W-1:0]          dvd;
  logic [DSR_W:0]            drem;
  logic [DSR_W-1:0]          dsr;
  div_job_t                  dj;
  logic [N_W-1:0]            n_pts, idx;
  logic [31:0]               qs, bq;
  logic [DEG_W-1:0]          rs, brem;
  logic signed [CS_W-1:0]    cx, cy, c_r, s_r;
  logic signed [Z_W-1:0]     cz;
  logic [IT_W-1:0]           it;
  logic [1:0]                quad;
  logic signed [MB_W-1:0]    omc;
  logic [OP_W-1:0]           op;
  logic [1:0]                mst;
  logic [PP_W-1:0]           mlo, mhi;
  logic [PROD_W-1:0]         mprod;
  logic                      mneg;

  // Combinational helpers.
  logic                      axis_zero, out_free, norm_done;
  mop_t                      m;
  logic signed [MA_W-1:0]    amux;
  logic signed [MB_W-1:0]    bmux;
  logic [MA_W-1:0]           amag;
  logic [MB_W-1:0]           bmag;
  logic [PROD_W-1:0]         mround;
  logic signed [ACC_W-1:0]   term;
  logic [SQ_W-1:0]           sq_try;
  logic                      sq_ge;
  logic [DSR_W:0]            rem_sh;
  logic [DSR_W+1:0]          diff;
  logic                      dge;
  logic [DVD_W-1:0]          q_fin;
  logic [DSR_W:0]            r_fin;
  logic                      q_zero;
  logic signed [CS_W-1:0]    shx, shy;
  logic signed [Z_W-1:0]     atan_z;
  logic                      last_pt;
  logic [DEG_W-1:0]          rem_sum;

  function automatic logic [COORD_W-1:0] sat_out(input logic signed [COORD_W-1:0] ctr,
                                                 input logic signed [ACC_W-1:0] r,
                                                 input logic inv);
    logic signed [V_W-1:0] c50, r50, v;
    c50 = V_W'(ctr);
    r50 = V_W'(r);
    v   = inv ? (c50 - r50) : (c50 + r50);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[COORD_W-1:0];
  endfunction

  assign axis_zero = (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
  assign out_free  = !out_valid || out_ready;
  assign norm_done = ((ua0 | ua1 | ua2) >> 30) != '0;

  // Shared multiplier operand selection.
  always_comb begin
    m = mop_table(op);
    case (m.a)
      A_P0:    amux = MA_W'(p0);
      A_P1:    amux = MA_W'(p1);
      A_P2:    amux = MA_W'(p2);
      A_CR0:   amux = cr0;
      A_CR1:   amux = cr1;
      A_CR2:   amux = cr2;
      A_DOT:   amux = dot;
      A_W:     amux = w;
      A_UA0:   amux = $signed({8'd0, ua0});
      A_UA1:   amux = $signed({8'd0, ua1});
      A_UA2:   amux = $signed({8'd0, ua2});
      default: amux = '0;
    endcase
    case (m.b)
      B_K0:    bmux = MB_W'(k0);
      B_K1:    bmux = MB_W'(k1);
      B_K2:    bmux = MB_W'(k2);
      B_C:     bmux = MB_W'(c_r);
      B_S:     bmux = MB_W'(s_r);
      B_OMC:   bmux = omc;
      B_UA0:   bmux = $signed({4'd0, ua0});
      B_UA1:   bmux = $signed({4'd0, ua1});
      B_UA2:   bmux = $signed({4'd0, ua2});
      default: bmux = '0;
    endcase
    amag   = amux[MA_W-1] ? MA_W'(-amux) : amux;
    bmag   = bmux[MB_W-1] ? MB_W'(-bmux) : bmux;
    // Round half away from zero on the magnitude, then apply the sign.
    mround = (mprod + PROD_W'(1 << 29)) >> 30;
    term   = mneg ? -$signed(mround[ACC_W-1:0]) : $signed(mround[ACC_W-1:0]);
  end

  // Square root, divider and CORDIC step logic.
  always_comb begin
    sq_try = sqr + sqbit;
    sq_ge  = sqv >= sq_try;
    rem_sh = {drem[DSR_W-1:0], dvd[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    dge    = !diff[DSR_W+1];
    q_fin  = {dvd[DVD_W-2:0], dge};
    r_fin  = dge ? diff[DSR_W:0] : rem_sh;
    q_zero = q_fin == '0;
    shx    = cx >>> it;
    shy    = cy >>> it;
    atan_z = $signed({3'b000, atan_bam(5'(it))});
    last_pt = ({1'b0, idx} + 1'b1) == {1'b0, n_pts};
    rem_sum = brem + rs;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = axis_zero ? ST_ZERO : ST_NORM;
      ST_ZERO:     if (out_free) state_next = ST_IDLE;
      ST_NORM:     if (norm_done) state_next = ST_MUL;
      ST_MUL: begin
        if (mst == MST_LAST) begin
          if (op == OP_SQ_LAST)         state_next = ST_SQRT;
          else if (op == OP_SETUP_LAST) state_next = ST_POINT;
          else if (op == OP_LAST)       state_next = ST_EMIT;
        end
      end
      ST_SQRT:     if (cnt == SQRT_LAST) state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          if (dj == DJ_COUNT && q_zero) state_next = ST_IDLE;
          else if (dj == DJ_STEP)       state_next = ST_MUL;
          else                          state_next = ST_DIV_LOAD;
        end
      end
      ST_POINT:    state_next = ST_ANGLE;
      ST_ANGLE:    state_next = (bq[29:0] == '0) ? ST_QUAD : ST_CORDIC;
      ST_CORDIC:   if (it == IT_LAST) state_next = ST_QUAD;
      ST_QUAD:     state_next = ST_MUL;
      ST_EMIT:     if (out_free) state_next = last_pt ? ST_IDLE : ST_ANGLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      axis_x      <= '0;
      axis_y      <= '0;
      axis_z      <= AXIS_Z_RESET;
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      step_angle  <= STEP_RESET;
      invert_mode <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_ZERO || state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_X:   axis_x      <= $signed(cfg_data);
          REG_AXIS_Y:   axis_y      <= $signed(cfg_data);
          REG_AXIS_Z:   axis_z      <= $signed(cfg_data);
          REG_CENTER_X: center_x    <= $signed(cfg_data);
          REG_CENTER_Y: center_y    <= $signed(cfg_data);
          REG_CENTER_Z: center_z    <= $signed(cfg_data);
          REG_STEP:     step_angle  <= cfg_data[STEP_W-1:0];
          REG_INVERT:   invert_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          p0  <= P_W'(point_x) - P_W'(center_x);
          p1  <= P_W'(point_y) - P_W'(center_y);
          p2  <= P_W'(point_z) - P_W'(center_z);
          ua0 <= axis_x[COORD_W-1] ? COORD_W'(-axis_x) : axis_x;
          ua1 <= axis_y[COORD_W-1] ? COORD_W'(-axis_y) : axis_y;
          ua2 <= axis_z[COORD_W-1] ? COORD_W'(-axis_z) : axis_z;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_x         <= '0;
          out_y         <= '0;
          out_z         <= '0;
          last_of_orbit <= 1'b1;
          bad_axis      <= 1'b1;
        end
      end
      ST_NORM: begin
        op  <= '0;
        mst <= '0;
        sq  <= '0;
        dot <= '0;
        cr0 <= '0;
        cr1 <= '0;
        cr2 <= '0;
        if (!norm_done) begin
          ua0 <= ua0 << 1;
          ua1 <= ua1 << 1;
          ua2 <= ua2 << 1;
        end
      end
      ST_MUL: begin
        mst <= mst + 2'd1;
        case (mst)
          2'd0: mlo <= PP_W'(amag[HALF_A-1:0] * bmag[MAG_B-1:0]);
          2'd1: begin
            mhi  <= PP_W'(amag[2*HALF_A-1:HALF_A] * bmag[MAG_B-1:0]);
            mneg <= amux[MA_W-1] ^ bmux[MB_W-1];
          end
          2'd2: mprod <= {mhi, {HALF_A{1'b0}}} + PROD_W'(mlo);
          default: begin
            op <= op + 1'b1;
            case (m.d)
              D_SQ:  sq  <= sq + mprod[SQ_W-1:0];
              D_DOT: dot <= m.sub ? dot - term : dot + term;
              D_CR0: cr0 <= m.sub ? cr0 - term : cr0 + term;
              D_CR1: cr1 <= m.sub ? cr1 - term : cr1 + term;
              D_CR2: cr2 <= m.sub ? cr2 - term : cr2 + term;
              D_W:   w   <= m.sub ? w - term : w + term;
              D_R0:  r0  <= m.sub ? r0 - term : r0 + term;
              D_R1:  r1  <= m.sub ? r1 - term : r1 + term;
              D_R2:  r2  <= m.sub ? r2 - term : r2 + term;
              default: ;
            endcase
            if (op == OP_SQ_LAST) begin
              // The last square lands this cycle, so seed the root with the sum.
              sqv   <= sq + mprod[SQ_W-1:0];
              sqr   <= '0;
              sqbit <= SQ_W'(1) << 62;
              cnt   <= '0;
            end
          end
        endcase
      end
      ST_SQRT: begin
        cnt   <= cnt + 1'b1;
        sqbit <= sqbit >> 2;
        if (sq_ge) begin
          sqv <= sqv - sq_try;
          sqr <= (sqr >> 1) + sqbit;
        end else begin
          sqr <= sqr >> 1;
        end
        if (cnt == SQRT_LAST) dj <= DJ_K0;
      end
      ST_DIV_LOAD: begin
        cnt  <= '0;
        drem <= '0;
        case (dj)
          DJ_K0: begin
            dvd <= DVD_W'({ua0, 30'd0}) + DVD_W'(sqr[DSR_W-1:1]);
            dsr <= sqr[DSR_W-1:0];
          end
          DJ_K1: begin
            dvd <= DVD_W'({ua1, 30'd0}) + DVD_W'(sqr[DSR_W-1:1]);
            dsr <= sqr[DSR_W-1:0];
          end
          DJ_K2: begin
            dvd <= DVD_W'({ua2, 30'd0}) + DVD_W'(sqr[DSR_W-1:1]);
            dsr <= sqr[DSR_W-1:0];
          end
          DJ_COUNT: begin
            dvd <= DVD_W'(FULL_TURN);
            dsr <= DSR_W'(step_angle);
          end
          default: begin
            dvd <= DVD_W'({step_angle, 16'd0});
            dsr <= DSR_W'(DEG_FULL);
          end
        endcase
      end
      ST_DIV: begin
        cnt  <= cnt + 1'b1;
        dvd  <= q_fin;
        drem <= r_fin;
        if (cnt == DIV_LAST) begin
          dj <= div_job_t'(dj + 3'd1);
          case (dj)
            DJ_K0: k0 <= axis_x[COORD_W-1] ? -$signed(q_fin[COORD_W-1:0])
                                           : $signed(q_fin[COORD_W-1:0]);
            DJ_K1: k1 <= axis_y[COORD_W-1] ? -$signed(q_fin[COORD_W-1:0])
                                           : $signed(q_fin[COORD_W-1:0]);
            DJ_K2: k2 <= axis_z[COORD_W-1] ? -$signed(q_fin[COORD_W-1:0])
                                           : $signed(q_fin[COORD_W-1:0]);
            DJ_COUNT: n_pts <= (q_fin > DVD_W'(MAX_ORBIT)) ? N_W'(MAX_ORBIT)
                                                           : q_fin[N_W-1:0];
            default: begin
              qs <= q_fin[31:0];
              rs <= r_fin[DEG_W-1:0];
            end
          endcase
        end
      end
      ST_POINT: begin
        // Angle zero maps to (0 * 65536 + 180) / 360: quotient 0, remainder 180.
        bq   <= '0;
        brem <= DEG_HALF;
        idx  <= '0;
      end
      ST_ANGLE: begin
        quad <= bq[31:30];
        cz   <= $signed({3'b000, bq[29:0]});
        cx   <= (bq[29:0] == '0) ? ONE_Q30 : CORDIC_GAIN;
        cy   <= '0;
        it   <= '0;
        w    <= '0;
        r0   <= '0;
        r1   <= '0;
        r2   <= '0;
      end
      ST_CORDIC: begin
        it <= it + 1'b1;
        if (!cz[Z_W-1]) begin
          cx <= cx - shy;
          cy <= cy + shx;
          cz <= cz - atan_z;
        end else begin
          cx <= cx + shy;
          cy <= cy - shx;
          cz <= cz + atan_z;
        end
      end
      ST_QUAD: begin
        op  <= OP_POINT_FIRST;
        mst <= '0;
        case (quad)
          2'd0: begin
            c_r <= cx;
            s_r <= cy;
            omc <= MB_W'(ONE_Q30) - MB_W'(cx);
          end
          2'd1: begin
            c_r <= -cy;
            s_r <= cx;
            omc <= MB_W'(ONE_Q30) + MB_W'(cy);
          end
          2'd2: begin
            c_r <= -cx;
            s_r <= -cy;
            omc <= MB_W'(ONE_Q30) + MB_W'(cx);
          end
          default: begin
            c_r <= cy;
            s_r <= -cx;
            omc <= MB_W'(ONE_Q30) - MB_W'(cy);
          end
        endcase
      end
      ST_EMIT: begin
        if (out_free) begin
          out_x         <= sat_out(center_x, r0, invert_mode);
          out_y         <= sat_out(center_y, r1, invert_mode);
          out_z         <= sat_out(center_z, r2, invert_mode);
          last_of_orbit <= last_pt;
          bad_axis      <= 1'b0;
          idx           <= idx + 1'b1;
          // Step the binary angle by the precomputed quotient and remainder of
          // step * 65536 / 360; the remainder stays below twice the modulus.
          if (rem_sum >= DEG_FULL) begin
            brem <= rem_sum - DEG_FULL;
            bq   <= bq + qs + 32'd1;
          end else begin
            brem <= rem_sum;
            bq   <= bq + qs;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/arop_checker.sv =====
// Port-level assertion checker for the orbit point core, bound to the top level.
`default_nettype none
`include "axis_rotation_orbit_points_core_macros.svh"
module arop_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               last_of_orbit,
  input logic               bad_axis
);

  // A stalled result beat keeps its payload.
  `AROP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(last_of_orbit))

  // Once an input beat is taken the core is busy for at least the next cycle.
  `AROP_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)

  // A zero-axis result is a lone, final beat with zero coordinates.
  `AROP_ASSERT(a_bad_axis_form, clk, rst, out_valid && bad_axis |-> last_of_orbit && out_x == 0 && out_y == 0 && out_z == 0)

  // Reset empties the output register.
  `AROP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind axis_rotation_orbit_points_core arop_checker u_arop_checker (.*);
`default_nettype wire

// ===== test/arop_orbit_checker.sv =====
// Checker for the orbit point core: tracks configuration, predicts each orbit and compares beats.
module arop_orbit_checker
  import arop_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [COORD_W-1:0]   out_x,
  input  logic signed [COORD_W-1:0]   out_y,
  input  logic signed [COORD_W-1:0]   out_z,
  input  logic                        last_of_orbit,
  input  logic                        bad_axis,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last_pt;
    logic                      bad;
  } orbit_pt_t;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint GAIN_Q30 = 64'sd652032874;

  logic [31:0]       axis_r[3];
  logic [31:0]       center_r[3];
  logic [STEP_W-1:0] step_r;
  logic              invert_r;
  orbit_pt_t         orbit_q[$];

  function automatic longint atan_step(input int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  // Product of a Q2.30 factor and another value, rounded half away from zero.
  function automatic longint q30_mul(input longint a, input longint b);
    logic         neg;
    logic [63:0]  ua, ub;
    logic [127:0] prod;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'b0, ua} * {64'b0, ub};
    prod = (prod + (128'd1 << 29)) >> 30;
    if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic cordic_sin_cos(input logic [STEP_W-1:0] ang,
                                output longint c, output longint s);
    logic [63:0] t;
    logic [31:0] bam;
    longint      x, y, z, nx;
    t = (64'(ang) * 64'd65536 + 64'd180) / 64'd360;
    bam = t[31:0];
    z = longint'(bam[29:0]);
    x = GAIN_Q30;
    y = 0;
    if (z == 0) begin
      x = Q30_ONE;
    end else begin
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - atan_step(i);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + atan_step(i);
        end
        x = nx;
      end
    end
    case (bam[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_orbit(input logic signed [31:0] px, py, pz);
    longint            ctr[3], p[3], k[3], cr[3], pin[3], a, c, s, dot, w, r;
    logic [63:0]       ua[3], m, sq, nrm;
    logic [STEP_W-1:0] ang;
    int                n;
    orbit_pt_t         e;
    logic signed [31:0] res[3];
    pin[0] = px;
    pin[1] = py;
    pin[2] = pz;
    m = 0;
    for (int j = 0; j < 3; j++) begin
      ctr[j] = longint'($signed(center_r[j]));
      p[j] = pin[j] - ctr[j];
      a = longint'($signed(axis_r[j]));
      ua[j] = (a < 0) ? 64'(-a) : 64'(a);
      if (ua[j] > m) m = ua[j];
    end
    if (m == 0) begin
      e = '{x: '0, y: '0, z: '0, last_pt: 1'b1, bad: 1'b1};
      orbit_q = {orbit_q, e};
      return;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int j = 0; j < 3; j++) ua[j] = ua[j] << 1;
    end
    sq = 0;
    for (int j = 0; j < 3; j++) sq = sq + ua[j] * ua[j];
    nrm = root64(sq);
    for (int j = 0; j < 3; j++) begin
      k[j] = longint'(((ua[j] << 30) + nrm / 2) / nrm);
      if ($signed(axis_r[j]) < 0) k[j] = -k[j];
    end
    n = (step_r != 0) ? int'(FULL_TURN / step_r) : MAX_ORBIT_DEF;
    if (n > MAX_ORBIT_DEF) n = MAX_ORBIT_DEF;
    dot = q30_mul(p[0], k[0]) + q30_mul(p[1], k[1]) + q30_mul(p[2], k[2]);
    cr[0] = q30_mul(k[1], p[2]) - q30_mul(k[2], p[1]);
    cr[1] = q30_mul(k[2], p[0]) - q30_mul(k[0], p[2]);
    cr[2] = q30_mul(k[0], p[1]) - q30_mul(k[1], p[0]);
    ang = '0;
    for (int i = 0; i < n; i++) begin
      cordic_sin_cos(ang, c, s);
      w = q30_mul(dot, Q30_ONE - c);
      for (int j = 0; j < 3; j++) begin
        r = q30_mul(p[j], c) + q30_mul(cr[j], s) + q30_mul(k[j], w);
        res[j] = clamp32(invert_r ? ctr[j] - r : ctr[j] + r);
      end
      e = '{x: res[0], y: res[1], z: res[2], last_pt: (i + 1 == n), bad: 1'b0};
      orbit_q = {orbit_q, e};
      ang = ang + step_r;
    end
  endtask

  always @(posedge clk) begin : watch
    orbit_pt_t e, got;
    if (rst) begin
      axis_r[0] = '0;
      axis_r[1] = '0;
      axis_r[2] = 32'(AXIS_Z_RESET);
      center_r[0] = '0;
      center_r[1] = '0;
      center_r[2] = '0;
      step_r = STEP_RESET;
      invert_r = 1'b0;
      orbit_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_X:   axis_r[0] = cfg_data;
          REG_AXIS_Y:   axis_r[1] = cfg_data;
          REG_AXIS_Z:   axis_r[2] = cfg_data;
          REG_CENTER_X: center_r[0] = cfg_data;
          REG_CENTER_Y: center_r[1] = cfg_data;
          REG_CENTER_Z: center_r[2] = cfg_data;
          REG_STEP:     step_r = cfg_data[STEP_W-1:0];
          REG_INVERT:   invert_r = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{x: out_x, y: out_y, z: out_z, last_pt: last_of_orbit, bad: bad_axis};
        if (orbit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: x=%0d y=%0d z=%0d last=%0b bad=%0b",
                     out_x, out_y, out_z, last_of_orbit, bad_axis);
        end else begin
          e = orbit_q.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp x=%0d y=%0d z=%0d last=%0b bad=%0b, ",
                        "got x=%0d y=%0d z=%0d last=%0b bad=%0b"},
                       e.x, e.y, e.z, e.last_pt, e.bad,
                       out_x, out_y, out_z, last_of_orbit, bad_axis);
          end
        end
      end
      if (in_valid && in_ready) predict_orbit(point_x, point_y, point_z);
    end
    pending = orbit_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the orbit point core: stimulus, output stalls and the verdict.
module tb;
  import arop_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 4'd15;
  localparam int DEG = 65536;
  localparam int SETTLE_CYCLES = 1000;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEM_TARGET = 370;
  localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CMIN = 32'h8000_0000;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [COORD_W-1:0] point_x, point_y, point_z, out_x, out_y, out_z;
  logic last_of_orbit, bad_axis;
  int fail_count, pending, items_sent;
  bit calm, hold_req;

  axis_rotation_orbit_points_core u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .last_of_orbit(last_of_orbit), .bad_axis(bad_axis)
  );

  arop_orbit_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .last_of_orbit(last_of_orbit), .bad_axis(bad_axis),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_point(input logic [31:0] x, y, z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drains every expected beat, then lets any orbit without beats finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] ax, ay, az, cx, cy, cz,
                            input logic [STEP_W-1:0] stp, input logic inv);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_STEP, 32'(stp));
    write_reg(REG_INVERT, 32'(inv));
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: case ($urandom_range(0, 3))
           0: return CMAX;
           1: return CMIN;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'($signed($urandom_range(0, 2 * DEG * 200)) - DEG * 200);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0]       ax, ay, az, cx, cy, cz;
    logic [STEP_W-1:0] stp;
    int                burst;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default configuration: a third of a turn about z.
    send_point(32'h0, 32'h0, 32'h0);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMIN, 32'd196608);
    wait_idle();

    // Full-turn step gives a single point; inverted through an extreme center.
    set_config(CMIN, CMAX, 32'd1, CMAX, CMIN, 32'h0, FULL_TURN, 1'b1);
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_UNUSED_TOP, $urandom);
    cfg_write <= 1'b0;
    @(negedge clk);
    send_point(CMIN, CMAX, 32'hFFFF_FFFF);
    send_point(32'd1, 32'h0, CMIN);
    wait_idle();

    // Zero axis gives one flagged beat.
    set_config(32'h0, 32'h0, 32'h0, 32'd65536, 32'h0, 32'h0, STEP_RESET, 1'b1);
    send_point($urandom, $urandom, $urandom);
    wait_idle();

    // Step zero, step below minimum and minimum step all saturate the count.
    set_config(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, '0, 1'b0);
    send_point(32'd65536, 32'd131072, 32'h0);
    wait_idle();
    set_config(32'd1, 32'd1, 32'd1, 32'h0, 32'h0, 32'h0, 25'd368640, 1'b0);
    send_point(CMAX, 32'h0, CMIN);
    wait_idle();
    set_config(32'd1, 32'd0, 32'd0, 32'h0, 32'h0, 32'h0, 25'd1, 1'b1);
    send_point(32'd65536, 32'd65536, 32'h0);
    wait_idle();

    // Step beyond a full turn gives no beats at all; a half-turn step then gives two.
    set_config(CMAX, CMAX, CMAX, 32'h0, 32'h0, 32'h0, {STEP_W{1'b1}}, 1'b0);
    send_point(32'd65536, 32'h0, 32'h0);
    send_point(CMAX, CMIN, CMAX);
    wait_idle();
    set_config(CMAX, CMAX, CMAX, 32'h0, 32'h0, 32'h0, 25'(180 * DEG), 1'b0);
    send_point(CMAX, CMIN, CMAX);
    send_point(CMIN, CMAX, 32'h0);
    wait_idle();

    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - 40) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: begin ax = $urandom; ay = $urandom; az = $urandom; end
        1: begin
          ax = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          ay = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          az = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        end
        2: begin
          ax = '0; ay = '0; az = '0;
          case ($urandom_range(0, 2))
            0: ax = $urandom;
            1: ay = $urandom;
            default: az = $urandom;
          endcase
        end
        default: begin
          ax = rand_coord(); ay = rand_coord();
          az = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord();
          if ($urandom_range(0, 5) == 0) ax = '0;
          if (ax == 0 && $urandom_range(0, 1) == 0) ay = '0;
        end
      endcase
      cx = rand_coord();
      cy = rand_coord();
      cz = rand_coord();
      burst = 25;
      case ($urandom_range(0, 9))
        0: begin
          stp = 25'($urandom_range(368640, 1474560));
          burst = 2;
        end
        9: case ($urandom_range(0, 3))
             0: begin stp = '0; burst = 1; end
             1: begin stp = 25'($urandom_range(1, 368639)); burst = 1; end
             2: stp = FULL_TURN;
             default: stp = 25'($urandom_range(23592961, 33554431));
           endcase
        default: stp = 25'($urandom_range(45 * DEG, 360 * DEG));
      endcase
      set_config(ax, ay, az, cx, cy, cz, stp, 1'($urandom_range(0, 1)));
      repeat (burst) send_point(rand_coord(), rand_coord(), rand_coord());
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/arop_pkg.sv
sv/axis_rotation_orbit_points_core.sv
sv/arop_checker.sv
test/arop_orbit_checker.sv
test/tb.sv
